// ===== rtl/m3inv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types for the 3x3 matrix inverse
// Item structs and fixed field widths.
// ----------------------------------------------------------------------------
package m3inv_pkg;

   localparam int IDX_W      = 4;
   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic [IDX_W-1:0]      element_index;
      logic [DATA_WIDTH-1:0] element_value;
      logic                  start_compute;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]      result_index;
      logic [DATA_WIDTH-1:0] inverse_value;
      logic [DATA_WIDTH-1:0] determinant;
      logic                  singular;
      logic                  last_result;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/m3inv_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_div: restoring divider on magnitudes
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module m3inv_div #(
   parameter int NUM_W = 128,
   parameter int DEN_W = 96
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      diff  = {1'b0, trial} - {2'b00, den};
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (go) begin
         q_in = num;
         r_in = '0;
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DEN_W+1]) begin
            r_in = diff[DEN_W:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule
`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 fixed-point matrix inverse by adjugate
// Stores elements, then emits the nine inverse elements on request.
// ----------------------------------------------------------------------------
// Usage: drive req_item and pulse start while busy is low. Each item writes
// one element of the nine-entry store (index 9..15 writes nothing). With
// start_compute set, busy rises and the block works on the stored matrix.
// A compute item runs 24 multiply steps: 18 cofactor products on one
// shared DATA_WIDTH x DATA_WIDTH multiplier, then 3 determinant products
// of width (2*DATA_WIDTH+1) x DATA_WIDTH, each split in two halves, on a
// separate multiplier; then nine divisions run on one bit-serial divider
// with a 4*DATA_WIDTH-bit quotient. Results appear on rsp_item one per
// cycle-pulse of rsp_valid, each strobe lasting one cycle; the receiver
// cannot stall. A singular matrix gives a single result with singular set.
// Reset clears the store to zeros and leaves the block idle.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire m3inv_pkg::req_type  req_item,
   output logic                     rsp_valid,
   output m3inv_pkg::rsp_type       rsp_item
);
   import m3inv_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int PW   = 2 * DW;        // product
   localparam int CW   = PW + 1;        // cofactor, signed
   localparam int TW   = 3 * DW + 2;    // determinant, signed
   localparam int NW   = 4 * DW;        // dividend magnitude
   localparam int DNW  = TW;            // divisor magnitude
   localparam int SW   = 5;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DET, S_CHECK, S_DIV, S_WAIT, S_EMIT
   } state_type;

   logic signed [DW-1:0] store_ff [9];
   logic signed [CW-1:0] cof_ff [9];
   state_type            state_ff;
   logic [SW-1:0]        step_ff;
   logic [3:0]           k_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [TW-1:0] det_ff;
   logic signed [TW-1:0] dacc_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic signed [DW-1:0] det_out_ff;

   // multiplier operand selection
   logic signed [DW-1:0]   ma, mb;
   logic signed [PW-1:0]   mp;
   logic [3:0]             ia, ib, kk;
   logic                   second;

   function automatic logic [3:0] adj_sel(input logic [3:0] k, input logic [1:0] j);
      logic [15:0] row;
      case (k)
         4'd0: row = {4'd4, 4'd8, 4'd5, 4'd7};
         4'd1: row = {4'd2, 4'd7, 4'd1, 4'd8};
         4'd2: row = {4'd1, 4'd5, 4'd2, 4'd4};
         4'd3: row = {4'd5, 4'd6, 4'd3, 4'd8};
         4'd4: row = {4'd0, 4'd8, 4'd2, 4'd6};
         4'd5: row = {4'd2, 4'd3, 4'd0, 4'd5};
         4'd6: row = {4'd3, 4'd7, 4'd4, 4'd6};
         4'd7: row = {4'd1, 4'd6, 4'd0, 4'd7};
         4'd8: row = {4'd0, 4'd4, 4'd1, 4'd3};
         default: row = '0;
      endcase
      return row[15 - 4*j -: 4];
   endfunction

   // determinant step: e[j] * cof[3j] split as cof = hi*2^DW + lo (lo unsigned)
   logic [1:0]             dj;
   logic signed [CW-1:0]   dcof;
   logic signed [DW:0]     dhi;
   logic [DW-1:0]          dlo;
   logic signed [PW+1:0]   dmul;

   always_comb begin
      kk = 4'(step_ff >> 1);
      second = step_ff[0];
      ia = adj_sel(kk, second ? 2'd2 : 2'd0);
      ib = adj_sel(kk, second ? 2'd3 : 2'd1);
      ma = store_ff[ia];
      mb = store_ff[ib];
      mp = PW'(ma * mb);
      dj = 2'(step_ff >> 1);
      dcof = cof_ff[4'(3 * dj)];
      dhi = dcof[CW-1:DW];
      dlo = dcof[DW-1:0];
      if (step_ff[0])
         dmul = (PW+2)'($signed({1'b0, dlo}) * store_ff[4'(dj)]);
      else
         dmul = (PW+2)'(dhi * store_ff[4'(dj)]);
   end

   // divider
   logic             div_go, div_done;
   logic [NW-1:0]    div_num, div_quo;
   logic [DNW-1:0]   div_den;
   logic             qneg_ff;
   logic signed [CW-1:0] ck;
   logic [CW-1:0]    cmag;
   logic [TW-1:0]    dmag;

   always_comb begin
      ck = cof_ff[k_ff];
      cmag = ck[CW-1] ? CW'(-ck) : CW'(ck);
      dmag = det_ff[TW-1] ? TW'(-det_ff) : TW'(det_ff);
      div_num = NW'({cmag, {(2*FRAC_BITS){1'b0}}});
      div_den = dmag;
   end

   m3inv_div #(.NUM_W(NW), .DEN_W(DNW)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign div_go = (state_ff == S_DIV);

   // saturation
   localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

   logic [DW-1:0] qsat;
   logic [TW-1:0] dshm;
   logic [DW-1:0] dsat;

   always_comb begin
      if (qneg_ff)
         qsat = (div_quo > NW'(SMIN)) ? SMIN : DW'(-div_quo);
      else
         qsat = (div_quo > NW'(SMAX)) ? SMAX : div_quo[DW-1:0];
      dshm = dmag >> (2 * FRAC_BITS);
      if (det_ff[TW-1])
         dsat = (dshm > TW'(SMIN)) ? SMIN : DW'(-dshm);
      else
         dsat = (dshm > TW'(SMAX)) ? SMAX : dshm[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
         k_ff <= '0;
         for (int i = 0; i < 9; i++) store_ff[i] <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_item.element_index <= 4'd8)
                     store_ff[req_item.element_index] <= DW'(signed'(req_item.element_value));
                  if (req_item.start_compute) begin
                     state_ff <= S_MUL;
                     step_ff <= '0;
                  end
               end
            end
            S_MUL: begin
               // step 2k: product p*q; 2k+1: subtract r*s
               prod_ff <= mp;
               if (step_ff[0])
                  cof_ff[kk] <= CW'(prod_ff) - CW'(mp);
               if (step_ff == SW'(17)) begin
                  state_ff <= S_DET;
                  step_ff <= '0;
                  dacc_ff <= '0;
               end else
                  step_ff <= step_ff + 1'b1;
            end
            S_DET: begin
               if (step_ff[0])
                  dacc_ff <= dacc_ff + TW'(dmul);
               else
                  dacc_ff <= dacc_ff + TW'({dmul, {DW{1'b0}}});
               if (step_ff == SW'(5)) begin
                  state_ff <= S_CHECK;
               end else
                  step_ff <= step_ff + 1'b1;
            end
            S_CHECK: begin
               det_ff <= dacc_ff;
               k_ff <= '0;
               state_ff <= S_WAIT;
               step_ff <= '0;
               if (dacc_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{result_index: '0, inverse_value: '0,
                              determinant: '0, singular: 1'b1, last_result: 1'b1};
                  state_ff <= S_IDLE;
               end else
                  state_ff <= S_EMIT;
            end
            S_EMIT: begin
               det_out_ff <= dsat;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               qneg_ff <= (ck[CW-1] != det_ff[TW-1]) && (ck != '0);
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{result_index: k_ff,
                              inverse_value: qsat,
                              determinant: det_out_ff,
                              singular: 1'b0, last_result: (k_ff == 4'd8)};
                  if (k_ff == 4'd8)
                     state_ff <= S_IDLE;
                  else begin
                     k_ff <= k_ff + 1'b1;
                     state_ff <= S_DIV;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
endmodule
`default_nettype wire
